/* hw/rtl/itda_pkg.sv */
// ----------------------------------------------------------------------------
// itda_pkg: shared definitions for the decimal text converter
// Character codes, double dabble constants, sizing helper and the control/status structs passed
// between the sequencer and the binary-to-BCD unit.
// ----------------------------------------------------------------------------
package itda_pkg;

  // default width of the signed input value
  localparam int VALUE_BITS_DEF = 32;

  // ascii codes
  localparam logic [7:0] MINUS_CHAR = 8'd45;
  localparam logic [7:0] DIGIT_BASE = 8'd48;

  // double dabble: a digit at or above this value gets the correction added
  localparam logic [3:0] ADJ_LIMIT = 4'd5;
  localparam logic [3:0] ADJ_ADD   = 4'd3;

  // decimal digits needed for a value of the given bit width
  // (1233 / 4096 is just below log10(2))
  function automatic int digit_count(input int bits);
    int n;
    n = ((bits * 1233) >>> 12) + 1;
    return n;
  endfunction

  // sequencer to conversion unit
  typedef struct packed {
    logic start;  // load a new magnitude and begin the bit loop
    logic shift;  // drop the leading digit, shift the rest up
  } ctl_t;

  // conversion unit to sequencer
  typedef struct packed {
    logic       ready;  // bit loop finished, digits are valid
    logic [3:0] msd;    // current leading digit
  } stat_t;

endpackage

/* hw/rtl/itda_bcd.sv */
// ----------------------------------------------------------------------------
// itda_bcd: iterative binary-to-BCD unit
// Shift-and-add-3 over one input bit per cycle, then hands out the digits
// from the most significant end, one per shift command.
// ----------------------------------------------------------------------------
module itda_bcd #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF,
  parameter int DIGITS     = itda_pkg::digit_count(itda_pkg::VALUE_BITS_DEF)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  itda_pkg::ctl_t        ctl,
  input  logic [VALUE_BITS-1:0] mag,
  output itda_pkg::stat_t       stat
);

  localparam int BW = 4 * DIGITS;
  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [BW-1:0]         bcd;
  logic [CW-1:0]         count;
  logic [BW-1:0]         bcd_adj;

  // add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= itda_pkg::ADJ_LIMIT) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + itda_pkg::ADJ_ADD;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // bit loop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.start) begin
      count <= CW'(VALUE_BITS);
    end else if (count != '0) begin
      count <= count - CW'(1);
    end
  end

  // shared shift register: binary in, decimal digits out
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      bin <= mag;
      bcd <= '0;
    end else if (count != '0) begin
      {bcd, bin} <= {bcd_adj[BW-2:0], bin, 1'b0};
    end else if (ctl.shift) begin
      bcd <= {bcd[BW-5:0], 4'd0};
    end
  end

  assign stat.ready = (count == '0);
  assign stat.msd   = bcd[BW-1 -: 4];

endmodule

/* hw/rtl/int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: signed integer to decimal ascii text
// Sequence: the input transfer, the shift-add-3 bit loop over the value
// bits and the leading zero skip come before the first character is
// registered; one character per cycle after, while text_stall is low.
// A new value is not taken until the last character of the previous one
// has been loaded into the output register (number_stall outside idle).
// Reset: synchronous, clears the sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         number_valid,
  output logic                         number_stall,
  input  logic signed [VALUE_BITS-1:0] number,
  output logic                         text_valid,
  input  logic                         text_stall,
  output logic [7:0]                   text_char,
  output logic                         last_char
);

  localparam int DIGITS = itda_pkg::digit_count(VALUE_BITS);
  localparam int DW     = $clog2(DIGITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic                  neg, neg_next;
  logic [DW-1:0]         dcnt, dcnt_next;
  logic                  text_valid_next;
  logic [7:0]            text_char_next;
  logic                  last_char_next;
  logic [VALUE_BITS-1:0] raw, mag;
  logic                  in_xfer, slot_free;
  itda_pkg::ctl_t        ctl;
  itda_pkg::stat_t       stat;

  // magnitude as unsigned, so the most negative value converts cleanly
  assign raw = number;
  assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  assign number_stall = (state != S_IDLE);
  assign in_xfer      = number_valid && !number_stall;
  assign slot_free    = !text_valid || !text_stall;

  itda_bcd #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_bcd (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .mag  (mag),
    .stat (stat)
  );

  // sequencer and output register next values
  always_comb begin
    state_next      = state;
    neg_next        = neg;
    dcnt_next       = dcnt;
    ctl             = '0;
    text_valid_next = text_valid && text_stall;
    text_char_next  = text_char;
    last_char_next  = last_char;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          ctl.start  = 1'b1;
          neg_next   = raw[VALUE_BITS-1];
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (stat.ready) begin
          dcnt_next  = DW'(DIGITS);
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, always keep the last digit
        if (stat.msd == 4'd0 && dcnt != DW'(1)) begin
          ctl.shift = 1'b1;
          dcnt_next = dcnt - DW'(1);
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          text_valid_next = 1'b1;
          if (neg) begin
            text_char_next = itda_pkg::MINUS_CHAR;
            last_char_next = 1'b0;
            neg_next       = 1'b0;
          end else begin
            text_char_next = itda_pkg::DIGIT_BASE + {4'd0, stat.msd};
            last_char_next = (dcnt == DW'(1));
            ctl.shift      = 1'b1;
            dcnt_next      = dcnt - DW'(1);
            if (dcnt == DW'(1)) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      text_valid <= 1'b0;
    end else begin
      state      <= state_next;
      text_valid <= text_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    neg       <= neg_next;
    dcnt      <= dcnt_next;
    text_char <= text_char_next;
    last_char <= last_char_next;
  end

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_char == itda_pkg::MINUS_CHAR |-> !last_char)
    else $error("minus sign marked as last character");

  // every other character is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_char != itda_pkg::MINUS_CHAR |->
      text_char >= itda_pkg::DIGIT_BASE && text_char <= (itda_pkg::DIGIT_BASE + 8'd9))
    else $error("character outside digit range");

  // an input transfer starts the conversion loop
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_CONV && !stat.ready)
    else $error("conversion did not start after input transfer");

  // new characters are only produced from the emit state
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    text_valid && !$past(text_valid && text_stall) && !$past(rst) |->
      $past(state) == S_EMIT)
    else $error("character loaded outside emit state");

endmodule
